/* rtl/sals_pkg.sv */
// Shared types and constants of the set-associative LRU cache statistics block.
// No dependencies; imported by every module of the block except sals_set_mem.
`timescale 1ns / 1ps
package sals_pkg;

  localparam int TAG_W   = 30;
  localparam int AGE_W   = 3;
  localparam logic [AGE_W-1:0] AGE_MAX = 3'd7;
  localparam int CNT_W   = 32;
  localparam int NUM_CNT = 10;
  localparam int AMT_W   = 16;
  localparam int OFF_MIN = 2;
  localparam int OFF_MAX = 12;
  localparam int IN_W    = 40;
  localparam int OUT_W   = 328;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_STORE = 2'd1,
    MODE_FETCH = 2'd2,
    MODE_FLUSH = 2'd3
  } mode_t;

  // configuration register indexes
  localparam logic [2:0] REG_SPLIT     = 3'd0;
  localparam logic [2:0] REG_WBACK     = 3'd1;
  localparam logic [2:0] REG_WALLOC    = 3'd2;
  localparam logic [2:0] REG_WAYS      = 3'd3;
  localparam logic [2:0] REG_OFFSET    = 3'd4;
  localparam logic [2:0] REG_USET_BITS = 3'd5;
  localparam logic [2:0] REG_ISET_BITS = 3'd6;
  localparam logic [2:0] REG_DSET_BITS = 3'd7;

  // counter indexes; data stream counters sit at CNT_D_BASE + inst offset
  localparam logic [3:0] CNT_ACC    = 4'd0;
  localparam logic [3:0] CNT_MISS   = 4'd1;
  localparam logic [3:0] CNT_REPL   = 4'd2;
  localparam logic [3:0] CNT_FETCH  = 4'd3;
  localparam logic [3:0] CNT_CPBACK = 4'd4;
  localparam logic [3:0] CNT_D_BASE = 4'd5;
  localparam logic [3:0] CNT_LAST   = 4'd9;

  typedef struct packed {
    logic             valid;
    logic             dirty;
    logic [AGE_W-1:0] age;
    logic [TAG_W-1:0] tag;
  } line_t;

  typedef struct packed {
    logic hit;
    logic fill;
    logic evicted;
    logic victim_dirty;
  } look_t;

endpackage

/* rtl/set_assoc_lru_cache_stats.sv */
// Set-associative LRU cache simulator with per-stream traffic counters.
// Access: accept, read, update/write, ten counter steps, result;
// the ten counters share one saturating adder, one add per cycle.
// Flush: each swept set is read, then cleaned and written; up to 2*2^set_bits sets.
// Reset (rst_n low, synchronous): config to defaults, counters to zero, then a
// clearing pass over all NUM_CACHES*MAX_SETS rows (1024 by default) before in_tready rises.
`timescale 1ns / 1ps
module set_assoc_lru_cache_stats #(
  parameter int MAX_SETS   = 512,
  parameter int MAX_WAYS   = 8,
  parameter int NUM_CACHES = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [sals_pkg::IN_W-1:0]  in_tdata,   // mode[1:0], address[33:2], zero pad
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [sals_pkg::OUT_W-1:0] out_tdata,  // hit, evicted, ten 32-bit counters, pad
  input  logic                       cfg_wr_en,
  input  logic [2:0]                 cfg_addr,
  input  logic [3:0]                 cfg_wdata
);
  import sals_pkg::*;

  localparam int DEPTH  = NUM_CACHES * MAX_SETS;
  localparam int ROW_AW = $clog2(DEPTH);
  localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int SB_MAX = $clog2(MAX_SETS + 1) - 1;   // floor(log2(MAX_SETS))
  localparam int WC_W   = $clog2(MAX_WAYS + 1);
  localparam int LINE_W = $bits(line_t);
  localparam int ROW_W  = MAX_WAYS * LINE_W;

  typedef enum logic [7:0] {
    S_CLR  = 8'b0000_0001,
    S_IDLE = 8'b0000_0010,
    S_RD   = 8'b0000_0100,
    S_LOOK = 8'b0000_1000,
    S_CNT  = 8'b0001_0000,
    S_FRD  = 8'b0010_0000,
    S_FWR  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t state_r;

  // configuration
  logic       split_r, wback_r, walloc_r;
  logic [3:0] ways_r, off_r, uset_r, iset_r, dset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      split_r  <= 1'b0;
      wback_r  <= 1'b1;
      walloc_r <= 1'b1;
      ways_r   <= 4'd1;
      off_r    <= 4'd4;
      uset_r   <= 4'd9;
      iset_r   <= 4'd9;
      dset_r   <= 4'd9;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_SPLIT:     split_r  <= cfg_wdata[0];
        REG_WBACK:     wback_r  <= cfg_wdata[0];
        REG_WALLOC:    walloc_r <= cfg_wdata[0];
        REG_WAYS:      ways_r   <= cfg_wdata;
        REG_OFFSET:    off_r    <= cfg_wdata;
        REG_USET_BITS: uset_r   <= cfg_wdata;
        REG_ISET_BITS: iset_r   <= cfg_wdata;
        REG_DSET_BITS: dset_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // effective geometry
  logic [WC_W-1:0]  ways_eff;
  logic [3:0]       off_eff, wshift;
  logic [AMT_W-1:0] words;

  always_comb begin
    if (ways_r == 4'd0)                       ways_eff = WC_W'(1);
    else if ({1'b0, ways_r} > 5'(MAX_WAYS))   ways_eff = WC_W'(MAX_WAYS);
    else                                      ways_eff = WC_W'(ways_r);
    if (off_r < 4'(OFF_MIN))                  off_eff = 4'(OFF_MIN);
    else if (off_r > 4'(OFF_MAX))             off_eff = 4'(OFF_MAX);
    else                                      off_eff = off_r;
  end
  assign wshift = off_eff - 4'(OFF_MIN);
  assign words  = AMT_W'(1) << wshift;

  function automatic logic [3:0] sat_bits(input logic [3:0] b);
    return (b > 4'(SB_MAX)) ? 4'(SB_MAX) : b;
  endfunction

  // latched item
  logic [1:0]  mode_r;
  logic [31:0] addr_r;
  logic        inst, store, cache_sel;
  logic [3:0]  acc_bits;
  logic [SET_W-1:0]  acc_set;
  logic [TAG_W-1:0]  acc_tag;
  logic [31:0] set_mask;
  logic [4:0]  tag_sh;

  assign inst      = mode_r == MODE_FETCH;
  assign store     = mode_r == MODE_STORE;
  assign cache_sel = split_r && !inst;
  assign acc_bits  = sat_bits(split_r ? (inst ? iset_r : dset_r) : uset_r);
  assign set_mask  = (32'd1 << acc_bits) - 32'd1;
  assign acc_set   = SET_W'((addr_r >> off_eff) & set_mask);
  assign tag_sh    = {1'b0, off_eff} + {1'b0, acc_bits};
  assign acc_tag   = TAG_W'(addr_r >> tag_sh);

  // flush sweep position
  logic             fl_c_r;
  logic [SET_W-1:0] fl_s_r;
  logic [3:0]       fl_bits;
  logic [SET_W-1:0] fl_last;

  assign fl_bits = sat_bits(split_r ? (fl_c_r ? dset_r : iset_r) : uset_r);
  assign fl_last = SET_W'((32'd1 << fl_bits) - 32'd1);

  logic [ROW_AW-1:0] clr_row_r, row_addr;
  logic              row_c;
  logic [SET_W-1:0]  row_s;

  assign row_c    = state_r[$clog2(S_FRD)] || state_r[$clog2(S_FWR)] ? fl_c_r : cache_sel;
  assign row_s    = state_r[$clog2(S_FRD)] || state_r[$clog2(S_FWR)] ? fl_s_r : acc_set;
  assign row_addr = row_c ? ROW_AW'(MAX_SETS) + ROW_AW'(row_s) : ROW_AW'(row_s);

  // set memory and way logic
  logic                      mem_we, mem_re;
  logic [ROW_AW-1:0]         mem_waddr;
  logic [ROW_W-1:0]          mem_wdata, mem_rdata;
  line_t [MAX_WAYS-1:0]      upd_row, clean_row;
  look_t                     look;
  logic [WC_W-1:0]           dirty_cnt;

  sals_set_mem #(.DEPTH(DEPTH), .AW(ROW_AW), .DW(ROW_W)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (row_addr),
    .rdata (mem_rdata)
  );

  sals_way_logic #(.MAX_WAYS(MAX_WAYS), .WC_W(WC_W)) u_ways (
    .row_i         (mem_rdata),
    .tag_i         (acc_tag),
    .ways_i        (ways_eff),
    .store_i       (store),
    .write_back_i  (wback_r),
    .write_alloc_i (walloc_r),
    .upd_row_o     (upd_row),
    .clean_row_o   (clean_row),
    .look_o        (look),
    .dirty_cnt_o   (dirty_cnt)
  );

  always_comb begin
    mem_re    = (state_r == S_RD) || (state_r == S_FRD);
    mem_we    = 1'b0;
    mem_waddr = row_addr;
    mem_wdata = upd_row;
    case (state_r)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_row_r;
        mem_wdata = '0;
      end
      S_LOOK: mem_we = look.hit || look.fill;
      S_FWR: begin
        mem_we    = 1'b1;
        mem_wdata = clean_row;
      end
      default: ;
    endcase
  end

  // per-counter increments of the current access
  logic [NUM_CNT-1:0][AMT_W-1:0] amt_r, amt_nxt;
  logic [3:0]                    k_r, sb;

  always_comb begin
    sb      = inst ? 4'd0 : CNT_D_BASE;
    amt_nxt = '0;
    amt_nxt[sb + CNT_ACC] = AMT_W'(1);
    if (look.hit) begin
      if (store && !wback_r) amt_nxt[CNT_LAST] = AMT_W'(1);
    end else begin
      amt_nxt[sb + CNT_MISS] = AMT_W'(1);
      if (!look.fill) begin
        amt_nxt[CNT_LAST] = AMT_W'(1);
      end else begin
        amt_nxt[sb + CNT_FETCH] = words;
        if (look.evicted) begin
          amt_nxt[sb + CNT_REPL] = AMT_W'(1);
          if (look.victim_dirty) amt_nxt[sb + CNT_CPBACK] = words;
        end
        // write-through store on a dirty data eviction lands on the same counter
        if (store && !wback_r) amt_nxt[CNT_LAST] = amt_nxt[CNT_LAST] + AMT_W'(1);
      end
    end
  end

  // shared adder requests
  logic                          add_en;
  logic [3:0]                    add_idx;
  logic [AMT_W-1:0]              add_amt;
  logic [NUM_CNT-1:0][CNT_W-1:0] cnt;

  always_comb begin
    add_en  = 1'b0;
    add_idx = k_r;
    add_amt = amt_r[k_r];
    case (state_r)
      S_CNT: add_en = 1'b1;
      S_FWR: begin
        add_en  = 1'b1;
        add_idx = CNT_LAST;
        add_amt = AMT_W'(dirty_cnt) << wshift;
      end
      default: ;
    endcase
  end

  sals_stat_unit u_stats (
    .clk     (clk),
    .rst_n   (rst_n),
    .add_en  (add_en),
    .add_idx (add_idx),
    .add_amt (add_amt),
    .cnt_o   (cnt)
  );

  // sequencer
  logic hit_r, evicted_r, out_valid_r, out_load;
  logic [OUT_W-1:0] out_data_r;

  assign in_tready = state_r == S_IDLE;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      clr_row_r <= '0;
      k_r       <= '0;
      fl_c_r    <= 1'b0;
      fl_s_r    <= '0;
    end else begin
      case (state_r)
        S_CLR: begin
          clr_row_r <= clr_row_r + 1'b1;
          if (clr_row_r == ROW_AW'(DEPTH - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_tvalid) begin
            fl_c_r  <= 1'b0;
            fl_s_r  <= '0;
            state_r <= (in_tdata[1:0] == MODE_FLUSH) ? S_FRD : S_RD;
          end
        end
        S_RD:   state_r <= S_LOOK;
        S_LOOK: begin
          k_r     <= '0;
          state_r <= S_CNT;
        end
        S_CNT: begin
          k_r <= k_r + 1'b1;
          if (k_r == CNT_LAST) state_r <= S_DONE;
        end
        S_FRD:  state_r <= S_FWR;
        S_FWR: begin
          if (fl_s_r == fl_last) begin
            if (!fl_c_r && split_r) begin
              fl_c_r  <= 1'b1;
              fl_s_r  <= '0;
              state_r <= S_FRD;
            end else begin
              state_r <= S_DONE;
            end
          end else begin
            fl_s_r  <= fl_s_r + 1'b1;
            state_r <= S_FRD;
          end
        end
        S_DONE: if (out_load) state_r <= S_IDLE;
        default: state_r <= S_CLR;
      endcase
    end
  end

  // item payload
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      mode_r    <= in_tdata[1:0];
      addr_r    <= in_tdata[33:2];
      hit_r     <= 1'b0;
      evicted_r <= 1'b0;
    end else if (state_r == S_LOOK) begin
      hit_r     <= look.hit;
      evicted_r <= look.evicted;
    end
    if (state_r == S_LOOK) amt_r <= amt_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {{(OUT_W - 2 - NUM_CNT * CNT_W){1'b0}}, cnt, evicted_r, hit_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word accepted while busy");

  a_hit_xor_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("hit and eviction on one access");

  a_acc_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> cnt[CNT_D_BASE] >= $past(cnt[CNT_D_BASE]))
    else $error("data access counter went down");

endmodule

/* rtl/sals_set_mem.sv */
// Set memory: one row per cache set, all ways side by side, registered read.
// Depends on nothing.
`timescale 1ns / 1ps
module sals_set_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 280
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/sals_way_logic.sv */
// Way compare, victim choice and LRU age update for one set row.
// Depends on sals_pkg.
`timescale 1ns / 1ps
module sals_way_logic #(
  parameter int MAX_WAYS = 8,
  parameter int WC_W     = 4
) (
  input  sals_pkg::line_t [MAX_WAYS-1:0]   row_i,
  input  logic [sals_pkg::TAG_W-1:0]       tag_i,
  input  logic [WC_W-1:0]                  ways_i,
  input  logic                             store_i,
  input  logic                             write_back_i,
  input  logic                             write_alloc_i,
  output sals_pkg::line_t [MAX_WAYS-1:0]   upd_row_o,
  output sals_pkg::line_t [MAX_WAYS-1:0]   clean_row_o,
  output sals_pkg::look_t                  look_o,
  output logic [WC_W-1:0]                  dirty_cnt_o
);
  import sals_pkg::*;

  localparam int WI_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

  logic [MAX_WAYS-1:0] inuse, hit_vec, inv_vec;
  logic [WI_W-1:0]     found, first_inv, best, tgt;
  logic [AGE_W-1:0]    best_age;
  logic [AGE_W:0]      limit;
  logic                hit, has_inv, fill, touch;

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      inuse[w]   = WC_W'(w) < ways_i;
      hit_vec[w] = inuse[w] && row_i[w].valid && (row_i[w].tag == tag_i);
      inv_vec[w] = inuse[w] && !row_i[w].valid;
    end
    found     = '0;
    first_inv = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) found = WI_W'(w);
      if (inv_vec[w]) first_inv = WI_W'(w);
    end
    // oldest way, lowest index wins a tie
    best     = '0;
    best_age = row_i[0].age;
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (inuse[w] && row_i[w].age > best_age) begin
        best     = WI_W'(w);
        best_age = row_i[w].age;
      end
    end
  end

  assign hit     = |hit_vec;
  assign has_inv = |inv_vec;
  assign fill    = !hit && !(store_i && !write_alloc_i);
  assign touch   = hit || fill;
  assign tgt     = hit ? found : (has_inv ? first_inv : best);
  assign limit   = hit ? {1'b0, row_i[found].age} : {1'b1, {AGE_W{1'b0}}};

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      upd_row_o[w] = row_i[w];
      if (touch) begin
        if (WI_W'(w) == tgt) begin
          upd_row_o[w].age = '0;
          if (fill) begin
            upd_row_o[w].valid = 1'b1;
            upd_row_o[w].tag   = tag_i;
            upd_row_o[w].dirty = store_i && write_back_i;
          end else if (store_i) begin
            upd_row_o[w].dirty = write_back_i;
          end
        end else if (inuse[w] && row_i[w].valid && ({1'b0, row_i[w].age} < limit)
                     && row_i[w].age != AGE_MAX) begin
          upd_row_o[w].age = row_i[w].age + 1'b1;
        end
      end
    end
  end

  always_comb begin
    dirty_cnt_o = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      clean_row_o[w] = row_i[w];
      if (inuse[w] && row_i[w].valid && row_i[w].dirty) begin
        clean_row_o[w].dirty = 1'b0;
        dirty_cnt_o          = dirty_cnt_o + 1'b1;
      end
    end
  end

  assign look_o.hit          = hit;
  assign look_o.fill         = fill;
  assign look_o.evicted      = fill && !has_inv;
  assign look_o.victim_dirty = row_i[best].dirty;

endmodule

/* rtl/sals_stat_unit.sv */
// Statistics counter bank with one shared saturating adder.
// Depends on sals_pkg.
`timescale 1ns / 1ps
module sals_stat_unit (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  logic                                               add_en,
  input  logic [3:0]                                         add_idx,
  input  logic [sals_pkg::AMT_W-1:0]                         add_amt,
  output logic [sals_pkg::NUM_CNT-1:0][sals_pkg::CNT_W-1:0]  cnt_o
);
  import sals_pkg::*;

  logic [NUM_CNT-1:0][CNT_W-1:0] cnt_r;
  logic [CNT_W:0]                sum;

  assign sum   = {1'b0, cnt_r[add_idx]} + (CNT_W + 1)'(add_amt);
  assign cnt_o = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (add_en) begin
      cnt_r[add_idx] <= sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
    end
  end

endmodule

/* tb/sv/tb_set_assoc_lru_cache_stats.sv */
// Testbench for set_assoc_lru_cache_stats: streams access words, predicts hit/evict
// and the ten traffic counters with a behavioral cache model. Depends on sals_pkg.
`timescale 1ns / 1ps
module tb_set_assoc_lru_cache_stats;
  import sals_pkg::*;

  localparam int N_SETS  = 512;
  localparam int N_WAYS  = 8;
  localparam int N_LINES = 2 * N_SETS * N_WAYS;
  localparam int SET_BITS_MAX = 9;   // log2(N_SETS)

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [IN_W-1:0]     in_tdata = '0;   // mode[1:0], address[33:2], zero pad
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_W-1:0]    out_tdata;       // hit, evicted, ten 32-bit counters, pad
  logic                cfg_wr_en = 1'b0;
  logic [2:0]          cfg_addr = '0;
  logic [3:0]          cfg_wdata = '0;

  always #5 clk = ~clk;

  set_assoc_lru_cache_stats uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  typedef struct {
    bit        hit;
    bit        evicted;
    bit [31:0] cnt [10];
  } stat_result_t;

  stat_result_t pending_results[$];
  int           errors = 0;

  // shadow configuration (raw register values, clamped on use)
  bit       sh_split, sh_wback, sh_walloc;
  bit [3:0] sh_ways, sh_off, sh_uset, sh_iset, sh_dset;

  // shadow cache state
  bit [29:0] sh_tag   [N_LINES];
  bit        sh_valid [N_LINES];
  bit        sh_dirty [N_LINES];
  bit [2:0]  sh_age   [N_LINES];
  bit [31:0] sh_cnt   [10];

  // address pool that gives the random part its reuse and set conflicts
  bit [31:0] addr_pool [24];

  function automatic bit [31:0] sat_add(bit [31:0] x, bit [31:0] y);
    bit [32:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[32] ? 32'hffff_ffff : s[31:0];
  endfunction

  function automatic int clamp_sets(bit [3:0] b);
    return (b > SET_BITS_MAX) ? SET_BITS_MAX : int'(b);
  endfunction

  function automatic int clamp_ways();
    if (sh_ways == 0) return 1;
    if (sh_ways > N_WAYS) return N_WAYS;
    return int'(sh_ways);
  endfunction

  function automatic int clamp_off();
    if (sh_off < OFF_MIN) return OFF_MIN;
    if (sh_off > OFF_MAX) return OFF_MAX;
    return int'(sh_off);
  endfunction

  task automatic model_reset();
    sh_split = 0; sh_wback = 1; sh_walloc = 1; sh_ways = 1;
    sh_off = 4; sh_uset = 9; sh_iset = 9; sh_dset = 9;
    for (int i = 0; i < N_LINES; i++) begin
      sh_tag[i] = '0; sh_valid[i] = 0; sh_dirty[i] = 0; sh_age[i] = '0;
    end
    foreach (sh_cnt[k]) sh_cnt[k] = '0;
  endtask

  // promote way w to MRU; valid ways younger than limit age by one (stop at 7)
  task automatic lru_touch(int base, int ways, int w, int limit);
    for (int i = 0; i < ways; i++)
      if (i != w && sh_valid[base+i] && sh_age[base+i] < limit && sh_age[base+i] < AGE_MAX)
        sh_age[base+i]++;
    sh_age[base+w] = '0;
  endtask

  // cache behavior for one accepted word; pushes the expected counters
  task automatic cache_predict(mode_t m, bit [31:0] a);
    stat_result_t r;
    int off, bits, ways, base, sb, found, victim, nc, ns;
    bit [31:0] words, set_idx;
    bit [29:0] tg;
    bit inst, store;
    r.hit = 0; r.evicted = 0;
    off   = clamp_off();
    words = 32'd1 << (off - 2);
    ways  = clamp_ways();
    if (m == MODE_FLUSH) begin
      nc = sh_split ? 2 : 1;
      for (int c = 0; c < nc; c++) begin
        ns = 1 << clamp_sets(sh_split ? (c == 0 ? sh_iset : sh_dset) : sh_uset);
        for (int s = 0; s < ns; s++)
          for (int w = 0; w < ways; w++) begin
            base = (c * N_SETS + s) * N_WAYS + w;
            if (sh_valid[base] && sh_dirty[base]) begin
              sh_dirty[base] = 0;
              sh_cnt[9] = sat_add(sh_cnt[9], words);
            end
          end
      end
    end else begin
      inst  = (m == MODE_FETCH);
      store = (m == MODE_STORE);
      bits  = clamp_sets(sh_split ? (inst ? sh_iset : sh_dset) : sh_uset);
      set_idx = (a >> off) & ((32'd1 << bits) - 1);
      tg    = 30'(a >> (off + bits));
      base  = (((sh_split && !inst) ? 1 : 0) * N_SETS + int'(set_idx)) * N_WAYS;
      sb    = inst ? 0 : CNT_D_BASE;
      found = ways;
      sh_cnt[sb+CNT_ACC] = sat_add(sh_cnt[sb+CNT_ACC], 1);
      for (int w = 0; w < ways; w++)
        if (found == ways && sh_valid[base+w] && sh_tag[base+w] == tg) found = w;
      if (found < ways) begin
        r.hit = 1;
        if (store) begin
          if (sh_wback) sh_dirty[base+found] = 1;
          else begin
            sh_dirty[base+found] = 0;
            sh_cnt[9] = sat_add(sh_cnt[9], 1);
          end
        end
        lru_touch(base, ways, found, int'(sh_age[base+found]));
      end else begin
        sh_cnt[sb+CNT_MISS] = sat_add(sh_cnt[sb+CNT_MISS], 1);
        if (store && !sh_walloc) begin
          // write around: one word straight to memory
          sh_cnt[9] = sat_add(sh_cnt[9], 1);
        end else begin
          sh_cnt[sb+CNT_FETCH] = sat_add(sh_cnt[sb+CNT_FETCH], words);
          victim = ways;
          for (int w = 0; w < ways; w++)
            if (victim == ways && !sh_valid[base+w]) victim = w;
          if (victim == ways) begin
            victim = 0;
            for (int w = 1; w < ways; w++)
              if (sh_age[base+w] > sh_age[base+victim]) victim = w;
            r.evicted = 1;
            sh_cnt[sb+CNT_REPL] = sat_add(sh_cnt[sb+CNT_REPL], 1);
            if (sh_dirty[base+victim])
              sh_cnt[sb+CNT_CPBACK] = sat_add(sh_cnt[sb+CNT_CPBACK], words);
          end
          sh_tag[base+victim]   = tg;
          sh_valid[base+victim] = 1;
          sh_dirty[base+victim] = store && sh_wback;
          if (store && !sh_wback) sh_cnt[9] = sat_add(sh_cnt[9], 1);
          lru_touch(base, ways, victim, AGE_MAX + 1);
        end
      end
    end
    r.cnt = sh_cnt;
    pending_results.push_back(r);
  endtask

  // sender gaps: mostly none or short, occasionally long
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // send one word, wait for acceptance, then update the prediction
  task automatic send_word(mode_t m, bit [31:0] a);
    int gap;
    in_tdata  <= {6'b0, a, m};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    cache_predict(m, a);
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off until every expected result is back, then let the block settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // only called while idle
  task automatic cfg_write(logic [2:0] idx, bit [3:0] val);
    cfg_wr_en <= 1'b1; cfg_addr <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_SPLIT:     sh_split  = val[0];
      REG_WBACK:     sh_wback  = val[0];
      REG_WALLOC:    sh_walloc = val[0];
      REG_WAYS:      sh_ways   = val;
      REG_OFFSET:    sh_off    = val;
      REG_USET_BITS: sh_uset   = val;
      REG_ISET_BITS: sh_iset   = val;
      default:       sh_dset   = val;
    endcase
  endtask

  task automatic cfg_all(bit sp, bit wb, bit wa, bit [3:0] wy, bit [3:0] of,
                         bit [3:0] us, bit [3:0] is, bit [3:0] ds);
    cfg_write(REG_SPLIT, {3'b0, sp});
    cfg_write(REG_WBACK, {3'b0, wb});
    cfg_write(REG_WALLOC, {3'b0, wa});
    cfg_write(REG_WAYS, wy);
    cfg_write(REG_OFFSET, of);
    cfg_write(REG_USET_BITS, us);
    cfg_write(REG_ISET_BITS, is);
    cfg_write(REG_DSET_BITS, ds);
  endtask

  // result checker: oldest expectation against each accepted result
  always @(posedge clk) begin
    stat_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h", $time, out_tdata);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_tdata[0] !== e.hit) begin
          $display("%0t: hit expected %0d actual %0d", $time, e.hit, out_tdata[0]);
          errors++;
        end
        if (out_tdata[1] !== e.evicted) begin
          $display("%0t: evicted expected %0d actual %0d", $time, e.evicted, out_tdata[1]);
          errors++;
        end
        for (int k = 0; k < 10; k++)
          if (out_tdata[2+32*k +: 32] !== e.cnt[k]) begin
            $display("%0t: counter %0d expected %0d actual %0d", $time, k, e.cnt[k],
                     out_tdata[2+32*k +: 32]);
            errors++;
          end
      end
    end
  end

  // receiver back-pressure: runs of ready with short and occasional long stalls
  int stall_left = 0;
  always @(posedge clk) begin
    int p;
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      p = $urandom_range(0, 99);
      if (p < 70) out_tready <= 1'b1;
      else begin
        out_tready <= 1'b0;
        stall_left <= (p < 96) ? $urandom_range(0, 3) : $urandom_range(10, 30);
      end
    end
  end

  // --- tests ---

  // reset geometry: cold misses, hits, dirty store, eviction by conflict, flush
  task automatic test_default_geometry();
    send_word(MODE_LOAD,  32'h0000_0000);
    send_word(MODE_LOAD,  32'h0000_0004);            // same block: hit
    send_word(MODE_STORE, 32'hffff_ffff);            // miss, allocate dirty
    send_word(MODE_STORE, 32'hffff_fff0);            // store hit
    send_word(MODE_FETCH, 32'h1234_5678);
    send_word(MODE_FETCH, 32'h1234_5678);
    send_word(MODE_LOAD,  32'h0000_fff0);            // conflicts with the dirty line
    send_word(MODE_FLUSH, 32'hffff_ffff);
    send_word(MODE_FLUSH, 32'h0000_0000);            // nothing left dirty
    drain();
  endtask

  // clamp behavior at the register extremes, write-through and write-around
  task automatic test_register_extremes();
    cfg_all(1, 0, 0, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15);
    send_word(MODE_STORE, 32'h8000_0000);            // write-around miss
    send_word(MODE_LOAD,  32'h8000_0000);
    send_word(MODE_STORE, 32'h8000_0010);            // write-through hit
    send_word(MODE_FETCH, 32'h8000_0000);            // separate I cache: miss
    drain();
    cfg_all(0, 1, 1, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0);
    send_word(MODE_STORE, 32'h0000_0000);
    send_word(MODE_LOAD,  32'h0000_0004);            // single line evicts dirty
    send_word(MODE_STORE, 32'h0000_0008);
    send_word(MODE_FLUSH, 32'h5555_5555);
    drain();
    cfg_all(0, 0, 1, 4'd8, 4'd12, 4'd9, 4'd9, 4'd9);
    send_word(MODE_STORE, 32'haaaa_aaaa);            // write-through allocate
    send_word(MODE_LOAD,  32'h5555_5555);
    send_word(MODE_FETCH, 32'hffff_ffff);
    drain();
  endtask

  task automatic random_phase(int n_items, bit hold_off);
    int p;
    bit [31:0] a;
    mode_t m;
    for (int i = 0; i < 24; i++) addr_pool[i] = $urandom();
    for (int i = 0; i < n_items; i++) begin
      p = $urandom_range(0, 99);
      if (p < 35)      m = MODE_LOAD;
      else if (p < 65) m = MODE_STORE;
      else if (p < 94) m = MODE_FETCH;
      else             m = MODE_FLUSH;
      a = ($urandom_range(0, 99) < 80) ? (addr_pool[$urandom_range(0, 23)] ^
          $urandom_range(0, 15)) : $urandom();
      send_word(m, a);
      if (hold_off && i == n_items / 2) drain();   // sender waits for all results
    end
    drain();
  endtask

  task automatic test_random_configs();
    bit [3:0] us, is, ds;
    for (int ph = 0; ph < 8; ph++) begin
      // small set counts most of the time so the pool conflicts and evicts
      us = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 2));
      is = 4'($urandom_range(0, 2));
      ds = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 2));
      cfg_all($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
              4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), us, is, ds);
      random_phase(78, ph == 2);
    end
  endtask

  initial begin
    model_reset();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_default_geometry();
    test_register_extremes();
    test_random_configs();
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #8ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
